@@ hw/rtl/crsm_pkg.sv @@
// Shared types, constants and codes for the contiguous ring space manager.
// Used by crsm_fifo and contiguous_ring_space_manager_core; depends on nothing.
package crsm_pkg;

    localparam int RING_BYTES_MAX = 65536;
    localparam int RING_W         = 17;
    localparam int POS_W          = 16;
    localparam int QDEPTH         = 64;
    localparam int QADDR_W        = 6;
    localparam int CNT_W          = 7;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_CONSUME = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_NO_READ   = 3'd4;

    typedef struct packed {
        logic             clr;
        logic             push;
        logic             pop;
        logic [POS_W-1:0] push_data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] front;
    } fifo_stat_t;

endpackage

@@ hw/rtl/crsm_fifo.sv @@
// Record length queue with a registered front entry, one push and one pop per cycle.
// Depends on crsm_pkg for widths, depth and the control and status structs.
module crsm_fifo
    import crsm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fifo_ctrl_t ctrl,
    output fifo_stat_t stat
);

    logic [POS_W-1:0]   mem [QDEPTH];
    logic [QADDR_W-1:0] head_reg;
    logic [QADDR_W-1:0] tail_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [POS_W-1:0]   front_reg;
    logic [QADDR_W-1:0] head_next;

    // The front register always holds the entry at the next head, so a pop
    // in every cycle still sees its data. A push to that same slot is forwarded.
    assign head_next = ctrl.pop ? head_reg + QADDR_W'(1) : head_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= ctrl.push_data;
        end
        if (ctrl.push && (tail_reg == head_next))
        begin
            front_reg <= ctrl.push_data;
        end
        else
        begin
            front_reg <= mem[head_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            if (ctrl.push)
            begin
                tail_reg <= tail_reg + QADDR_W'(1);
            end
            if (ctrl.push && !ctrl.pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (ctrl.pop && !ctrl.push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign stat.count = count_reg;
    assign stat.front = front_reg;

endmodule

@@ hw/rtl/contiguous_ring_space_manager_core.sv @@
// Top level of the contiguous ring space manager: pointer bookkeeping and handshakes.
// Depends on crsm_pkg and instantiates crsm_fifo for the unread and unconsumed queues.
//
// The block keeps the books for a byte ring of variable-length records that must
// stay contiguous. Each transaction on the slave side is one operation (write
// reserve, read next record, consume oldest read) and yields exactly one result
// transaction with a status, an offset and a size. An operation is registered on
// entry, evaluated combinationally against the pointers and the two record queues,
// and registered on exit, so one operation is taken every clock cycle while the
// master side is not stalled; the result is presented from the exit register.
// The rate is set by the single queue read port per queue, whose front entry is
// kept in a register. A padding record that fills the ring end is held in its own
// register rather than in the queue. Writing cfg_wdata sets the ring size (clamped
// to 2..65536) and empties the ring; do so only while no operation is in flight.
module contiguous_ring_space_manager_core
    import crsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [RING_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [15:0] length
    input  logic [1:0]        s_tuser,   // [1:0] func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // [15:0] offset, [31:16] size
    output logic [2:0]        m_tuser    // [2:0] status
);

    logic              in_valid_reg;
    logic [1:0]        in_func_reg;
    logic [POS_W-1:0]  in_len_reg;
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [POS_W-1:0]  out_offset_reg;
    logic [POS_W-1:0]  out_size_reg;
    logic              advance;

    logic [RING_W-1:0] ring_reg;
    logic [RING_W-1:0] ring_next;
    logic [POS_W-1:0]  wp_reg;
    logic [POS_W-1:0]  wp_next;
    logic [POS_W-1:0]  rp_reg;
    logic [POS_W-1:0]  rp_next;
    logic [RING_W-1:0] used_reg;
    logic [RING_W-1:0] used_next;
    logic              pad_valid_reg;
    logic              pad_valid_next;
    logic [CNT_W-1:0]  pad_ahead_reg;
    logic [CNT_W-1:0]  pad_ahead_next;
    logic [RING_W-1:0] pad_size_reg;
    logic [RING_W-1:0] pad_size_next;

    fifo_ctrl_t        rd_ctrl;
    fifo_stat_t        rd_stat;
    fifo_ctrl_t        cs_ctrl;
    fifo_stat_t        cs_stat;

    logic [2:0]        res_status;
    logic [POS_W-1:0]  res_offset;
    logic [POS_W-1:0]  res_size;

    logic [RING_W-1:0] len_w;
    logic [CNT_W-1:0]  rd_total;
    logic [RING_W-1:0] remain;
    logic [RING_W:0]   used_plus_len;
    logic [RING_W:0]   used_plus_remain;
    logic [RING_W:0]   mid_plus_len;
    logic [RING_W-1:0] used_mid;
    logic              pad_front;
    logic [POS_W-1:0]  rp_base;
    logic [RING_W-1:0] used_base;
    logic [RING_W-1:0] rp_sum;
    logic [RING_W-1:0] cs_front_w;

    // Handshakes: the operation register moves on whenever the result
    // register is empty or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_size_reg, out_offset_reg};
    assign m_tuser  = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= s_tuser;
            in_len_reg  <= s_tdata;
        end
        if (advance)
        begin
            out_status_reg <= res_status;
            out_offset_reg <= res_offset;
            out_size_reg   <= res_size;
        end
    end

    crsm_fifo u_rd_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rd_ctrl),
        .stat  (rd_stat)
    );

    crsm_fifo u_cs_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cs_ctrl),
        .stat  (cs_stat)
    );

    always_comb
    begin
        if (cfg_wdata < RING_W'(2))
        begin
            ring_next = RING_W'(2);
        end
        else if (cfg_wdata > RING_W'(RING_BYTES_MAX))
        begin
            ring_next = RING_W'(RING_BYTES_MAX);
        end
        else
        begin
            ring_next = cfg_wdata;
        end
    end

    // The unread count includes the padding record, which lives outside the queue.
    assign len_w            = {1'b0, in_len_reg};
    assign rd_total         = rd_stat.count + CNT_W'(pad_valid_reg);
    assign remain           = ring_reg - {1'b0, wp_reg};
    assign used_plus_len    = {1'b0, used_reg} + {1'b0, len_w};
    assign used_plus_remain = {1'b0, used_reg} + {1'b0, remain};
    assign used_mid         = used_plus_remain[RING_W-1:0];
    assign mid_plus_len     = {1'b0, used_mid} + {1'b0, len_w};
    assign pad_front        = pad_valid_reg && (pad_ahead_reg == '0);
    assign rp_base          = pad_front ? '0 : rp_reg;
    assign used_base        = !pad_front ? used_reg :
                              (pad_size_reg > used_reg) ? '0 : used_reg - pad_size_reg;
    assign rp_sum           = {1'b0, rp_base} + {1'b0, rd_stat.front};
    assign cs_front_w       = {1'b0, cs_stat.front};

    always_comb
    begin
        res_status        = ST_OK;
        res_offset        = '0;
        res_size          = '0;
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        used_next         = used_reg;
        pad_valid_next    = pad_valid_reg;
        pad_ahead_next    = pad_ahead_reg;
        pad_size_next     = pad_size_reg;
        rd_ctrl.clr       = cfg_we;
        rd_ctrl.push      = 1'b0;
        rd_ctrl.pop       = 1'b0;
        rd_ctrl.push_data = in_len_reg;
        cs_ctrl.clr       = cfg_we;
        cs_ctrl.push      = 1'b0;
        cs_ctrl.pop       = 1'b0;
        cs_ctrl.push_data = rd_stat.front;

        if (advance)
        begin
            case (in_func_reg)
                FUNC_WRITE:
                begin
                    if (len_w >= ring_reg)
                    begin
                        res_status = ST_TOO_LARGE;
                    end
                    else if ((used_plus_len > {1'b0, ring_reg}) ||
                             (rd_total == CNT_W'(QDEPTH)))
                    begin
                        res_status = ST_FULL;
                    end
                    else if (remain <= len_w)
                    begin
                        // The record would reach the ring end: pad to the end first.
                        if (used_plus_remain > {1'b0, ring_reg})
                        begin
                            res_status = ST_FULL;
                        end
                        else
                        begin
                            pad_valid_next = 1'b1;
                            pad_ahead_next = rd_stat.count;
                            pad_size_next  = remain;
                            wp_next        = '0;
                            used_next      = used_mid;
                            if ((mid_plus_len > {1'b0, ring_reg}) ||
                                (rd_total + CNT_W'(1) == CNT_W'(QDEPTH)))
                            begin
                                // The padding stays; a retry places the record at zero.
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                res_size     = in_len_reg;
                                rd_ctrl.push = 1'b1;
                                used_next    = mid_plus_len[RING_W-1:0];
                                wp_next      = in_len_reg;
                            end
                        end
                    end
                    else
                    begin
                        res_offset   = wp_reg;
                        res_size     = in_len_reg;
                        rd_ctrl.push = 1'b1;
                        used_next    = used_plus_len[RING_W-1:0];
                        wp_next      = wp_reg + in_len_reg;
                    end
                end
                FUNC_READ:
                begin
                    if (cs_stat.count == CNT_W'(QDEPTH))
                    begin
                        res_status = ST_FULL;
                    end
                    else if (rd_total == '0)
                    begin
                        res_status = ST_EMPTY;
                    end
                    else
                    begin
                        if (pad_front)
                        begin
                            pad_valid_next = 1'b0;
                        end
                        rp_next   = rp_base;
                        used_next = used_base;
                        if (pad_front && (rd_stat.count == '0))
                        begin
                            res_status = ST_EMPTY;
                        end
                        else
                        begin
                            res_offset   = rp_base;
                            res_size     = rd_stat.front;
                            rd_ctrl.pop  = 1'b1;
                            cs_ctrl.push = 1'b1;
                            rp_next      = (rp_sum >= ring_reg) ? '0 : rp_sum[POS_W-1:0];
                            if (pad_valid_reg && !pad_front)
                            begin
                                pad_ahead_next = pad_ahead_reg - CNT_W'(1);
                            end
                        end
                    end
                end
                FUNC_CONSUME:
                begin
                    if (cs_stat.count == '0)
                    begin
                        res_status = ST_NO_READ;
                    end
                    else
                    begin
                        res_size    = cs_stat.front;
                        cs_ctrl.pop = 1'b1;
                        used_next   = (cs_front_w > used_reg) ? '0 : used_reg - cs_front_w;
                    end
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg      <= RING_W'(RING_BYTES_MAX);
            wp_reg        <= '0;
            rp_reg        <= '0;
            used_reg      <= '0;
            pad_valid_reg <= 1'b0;
            pad_ahead_reg <= '0;
            pad_size_reg  <= '0;
        end
        else if (cfg_we)
        begin
            ring_reg      <= ring_next;
            wp_reg        <= '0;
            rp_reg        <= '0;
            used_reg      <= '0;
            pad_valid_reg <= 1'b0;
            pad_ahead_reg <= '0;
            pad_size_reg  <= '0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            used_reg      <= used_next;
            pad_valid_reg <= pad_valid_next;
            pad_ahead_reg <= pad_ahead_next;
            pad_size_reg  <= pad_size_next;
        end
    end

endmodule
